@@ rtl/vfd_pkg.sv @@
// ----------------------------------------------------------------------------
// vfd_pkg: shared types and constants of the frame descrambler
// Beat payloads, the stage record between tracker and decoder, and the
// per-position offset table.
// ----------------------------------------------------------------------------
package vfd_pkg;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
    } vfd_in_t;

    // Output beat
    typedef struct packed {
        logic [7:0] plain_byte;
        logic       last;
    } vfd_out_t;

    // Work record held in the input stage register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       descramble;
        logic [2:0] slot;
        logic [7:0] key_byte;
        logic [7:0] jump_start;
    } vfd_stage_t;

    localparam int unsigned SCRAMBLED_BYTES = 8;
    localparam int unsigned POS_W           = 4;

    localparam logic [POS_W-1:0] FIRST_POS = 4'd1;
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(SCRAMBLED_BYTES);
    localparam logic [POS_W-1:0] IDLE_POS  = 4'd9;

    localparam logic [7:0] JUMP_START_RESET = 8'h54;
    localparam logic [7:0] JUMP_SPAN        = 8'h80;
    localparam logic [7:0] OFFSET_BONUS     = 8'h80;

    // Offset by byte position (row) and key mod 4 (column)
    localparam logic [7:0] OFFSET_TABLE [SCRAMBLED_BYTES][4] = '{
        '{8'h45, 8'h1F, 8'h14, 8'h5C},
        '{8'h2B, 8'hC9, 8'hE3, 8'h11},
        '{8'hEE, 8'hDE, 8'h0B, 8'hAA},
        '{8'hAF, 8'h03, 8'h1D, 8'hF3},
        '{8'h1A, 8'hE2, 8'hF0, 8'hD1},
        '{8'h04, 8'hD8, 8'h71, 8'h42},
        '{8'hAF, 8'h04, 8'hDD, 8'h07},
        '{8'hE1, 8'h93, 8'hB8, 8'hE4}
    };

endpackage

@@ rtl/vfd_track.sv @@
// ----------------------------------------------------------------------------
// vfd_track: frame tracker and input stage register
// Follows frame position and key across beats, holds the jump start
// register, and loads one work record per accepted beat.
// ----------------------------------------------------------------------------
module vfd_track (
    input  logic              aclk,
    input  logic              aresetn,
    input  vfd_pkg::vfd_in_t  in_data,
    input  logic              in_valid,
    input  logic              load_en,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_data,
    output vfd_pkg::vfd_stage_t stage,
    output logic              stage_valid
);
    import vfd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       key_reg, key_next;
    logic [7:0]       jump_reg, jump_next;
    vfd_stage_t       stage_reg, stage_next;
    logic             stage_valid_reg, stage_valid_next;
    logic             take;
    logic             in_frame;

    assign take     = in_valid && load_en;
    assign in_frame = (pos_reg >= FIRST_POS) && (pos_reg <= LAST_POS);

    // Advance frame state and build the work record
    always_comb begin
        pos_next         = pos_reg;
        key_next         = key_reg;
        jump_next        = jump_reg;
        stage_next       = stage_reg;
        stage_valid_next = stage_valid_reg;

        if (cfg_valid) begin
            jump_next = cfg_data;
        end

        if (load_en) begin
            stage_valid_next = in_valid;
        end

        if (take) begin
            stage_next.data_byte  = in_data.data_byte;
            stage_next.last       = in_data.frame_end;
            stage_next.key_byte   = key_reg;
            stage_next.jump_start = jump_reg;
            stage_next.slot       = 3'(pos_reg - FIRST_POS);
            stage_next.descramble = 1'b0;
            if (in_data.frame_start) begin
                key_next = in_data.data_byte;
                pos_next = FIRST_POS;
            end else if (in_frame) begin
                stage_next.descramble = 1'b1;
                pos_next              = pos_reg + FIRST_POS;
            end else begin
                pos_next = IDLE_POS;
            end
            if (in_data.frame_end) begin
                pos_next = IDLE_POS;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= IDLE_POS;
            key_reg         <= '0;
            jump_reg        <= JUMP_START_RESET;
            stage_valid_reg <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            key_reg         <= key_next;
            jump_reg        <= jump_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
    end

    assign stage       = stage_reg;
    assign stage_valid = stage_valid_reg;

endmodule

@@ rtl/vfd_decode.sv @@
// ----------------------------------------------------------------------------
// vfd_decode: byte descrambler datapath
// Derives the XOR key from the key nibbles, picks the offset, subtracts it
// and applies the XOR key, or passes the byte through.
// ----------------------------------------------------------------------------
module vfd_decode (
    input  vfd_pkg::vfd_stage_t stage,
    output vfd_pkg::vfd_out_t   result
);
    import vfd_pkg::*;

    logic [3:0] lo_nib, hi_nib;
    logic       bump;
    logic [2:0] rot;
    logic [3:0] xor_hi, xor_lo;
    logic [7:0] xor_key;
    logic       bonus;
    logic [8:0] jump_top;
    logic [7:0] offset;
    logic [7:0] diff;

    // Derive the XOR key from the key byte nibbles
    always_comb begin
        lo_nib  = stage.key_byte[3:0];
        hi_nib  = stage.key_byte[7:4];
        bump    = (lo_nib >= 4'h4);
        rot     = hi_nib[2:0] + {2'b00, bump} + 3'd6;
        xor_hi  = (4'h4 + {1'b0, rot}) ^ 4'h1;
        xor_lo  = (lo_nib + 4'h4) ^ 4'h2;
        xor_key = {xor_hi, xor_lo};
    end

    // Pick the offset, with the bonus inside the jump window
    always_comb begin
        jump_top = {1'b0, stage.jump_start} + {1'b0, JUMP_SPAN};
        bonus    = (stage.jump_start != 8'h00)
                && (stage.key_byte >= stage.jump_start)
                && ({1'b0, stage.key_byte} <= jump_top);
        offset   = OFFSET_TABLE[stage.slot][stage.key_byte[1:0]];
        if (bonus) begin
            offset = offset + OFFSET_BONUS;
        end
    end

    // Subtract and unmask, or pass through
    always_comb begin
        diff        = stage.data_byte - offset;
        result.last = stage.last;
        if (stage.descramble) begin
            result.plain_byte = diff ^ xor_key;
        end else begin
            result.plain_byte = stage.data_byte;
        end
    end

endmodule

@@ rtl/v2_frame_descrambler_unit.sv @@
// An accepted beat goes through the stage register to the m_data register.
// Throughput: one beat per cycle while m_ready stays high; a stalled result
// blocks the input once the stage register behind it is also full.
// The rate is set by the single input stage register feeding the
// output register through the offset subtract and XOR.
// Reset (aresetn low, synchronous) empties both registers, sets the
// jump start to 0x54, the key to zero and the tracker to pass-through.
// ----------------------------------------------------------------------------
// v2_frame_descrambler_unit: frame descrambler top level
// Input stage via the tracker, descrambler datapath, output register.
// ----------------------------------------------------------------------------
module v2_frame_descrambler_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vfd_pkg::vfd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vfd_pkg::vfd_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);
    import vfd_pkg::*;

    vfd_stage_t stage;
    logic       stage_valid;
    vfd_out_t   decoded;
    logic       out_free;
    logic       m_valid_reg, m_valid_next;
    vfd_out_t   m_data_reg, m_data_next;

    // Output slot frees when empty or taken this cycle
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !stage_valid || out_free;
    assign cfg_ready = 1'b1;

    vfd_track u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_data     (s_data),
        .in_valid    (s_valid),
        .load_en     (s_ready),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .stage       (stage),
        .stage_valid (stage_valid)
    );

    vfd_decode u_decode (
        .stage  (stage),
        .result (decoded)
    );

    // Load the output register when it frees up
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free) begin
            m_valid_next = stage_valid;
            if (stage_valid) begin
                m_data_next = decoded;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/vfd_chk.sv @@
// ----------------------------------------------------------------------------
// vfd_chk: port-level checker for the frame descrambler
// Watches handshakes and reset behavior on the top-level ports.
// ----------------------------------------------------------------------------
module vfd_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input vfd_pkg::vfd_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input vfd_pkg::vfd_out_t m_data
);
    import vfd_pkg::*;

    // Upstream holds a stalled beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("input beat dropped or changed while stalled");

    // Hold a stalled result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat dropped or changed while stalled");

    // An empty or draining output slot never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with room downstream");

    // Reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present after reset");

endmodule

bind v2_frame_descrambler_unit vfd_chk u_vfd_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
